### hw/rtl/dsaw_pkg.sv
// Shared types, constants and tables for the DEM surface area window unit.
`default_nettype none

package dsaw_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int HEIGHT_BITS_DEF = 24;

    // Fixed field widths.
    localparam int DIM_W       = 24;
    localparam int COLS_W      = 11;
    localparam int ROWS_W      = 16;
    localparam int AREA_W      = 63;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PER_CELL_MODE = 3'd4;

    // Neighbour offsets clockwise from the upper left, the first repeated at the end.
    localparam logic signed [1:0] OFF_X [9] =
        '{-2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] OFF_Y [9] =
        '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1};

    // Window position (row * 3 + column) of each neighbour in ring order.
    localparam int unsigned RING_POS [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WH,
        ST_PAIR,
        ST_MULX,
        ST_MULY,
        ST_LATY,
        ST_SQM,
        ST_SQA,
        ST_ROOT,
        ST_ROOTW,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/dsaw_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module dsaw_sqrt #(
    parameter int RTW = 51
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2*RTW-1:0]  radicand,
    output logic                   done,
    output logic [RTW-1:0]         root
);
    localparam int RW   = 2 * RTW;
    localparam int REMW = RTW + 3;
    localparam int CNTW = $clog2(RTW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [RW-1:0]    rad_reg;
    logic [REMW-1:0]  rem_reg;
    logic [RTW-1:0]   root_reg;
    logic [REMW-1:0]  rem_sh;
    logic [REMW-1:0]  trial;
    logic             take;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb
    begin
        rem_sh = {rem_reg[REMW-3:0], rad_reg[RW-1:RW-2]};
        trial  = REMW'({root_reg, 2'b01});
        take   = (rem_sh >= trial);
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(RTW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and partial root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RTW-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### hw/rtl/dem_surface_area_window_unit.sv
// Top level of the DEM surface area window unit: line store, window and area sequencer.
// An interior cell with its centre present takes WH, then per triangle PAIR, MULX, MULY,
// LATY, SQM and SQA per partial product, ROOT and ROOTW, then DONE; other items go LOAD to
// DONE. One item is worked at a time; the next is accepted in the cycle after the result is
// registered; the shared multiplier and the one-bit-a-cycle square root set the cell time.
// Reset clears the counters, the window, the total and the output; the line store is not.
`default_nettype none

module dem_surface_area_window_unit #(
    parameter int MAX_COLUMNS = dsaw_pkg::MAX_COLUMNS_DEF,
    parameter int HEIGHT_BITS = dsaw_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [HEIGHT_BITS-1:0]       elevation,
    input  wire logic                                elevation_missing,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [dsaw_pkg::AREA_W-1:0]              area_value,
    output logic                                     center_missing,
    output logic                                     is_total,
    input  wire logic                                cfg_write,
    input  wire logic [dsaw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dsaw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dsaw_pkg::*;

    localparam int HB    = HEIGHT_BITS;
    localparam int EW    = HB + 1;
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int CMPW  = ((CW + 1 > COLS_W) ? CW + 1 : COLS_W) + 1;
    localparam int DW    = HB + 1;
    localparam int AW    = HB + 3;
    localparam int MGW   = HB + 2;
    localparam int CXW   = DIM_W + MGW;
    localparam int CZW   = 2 * DIM_W + 1;
    localparam int SW0   = (CXW > CZW) ? CXW : CZW;
    localparam int SW    = SW0 + (SW0 % 2);
    localparam int HALF  = SW / 2;
    localparam int MUL0  = (HALF > MGW) ? HALF : MGW;
    localparam int MULW  = (MUL0 > DIM_W) ? MUL0 : DIM_W;
    localparam int RTW   = SW + 1;
    localparam int RW    = 2 * RTW;
    localparam int SUMW  = RTW + 3;
    localparam int WHW   = 2 * DIM_W;

    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_LH = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;
    localparam logic [1:0] SQ_CX   = 2'd0;
    localparam logic [1:0] SQ_CY   = 2'd1;
    localparam logic [1:0] SQ_CZ   = 2'd2;

    // Scale a height difference by a neighbour offset of -1, 0 or 1.
    function automatic logic signed [AW-1:0] scale(input logic signed [1:0] off,
                                                   input logic signed [DW-1:0] v);
        logic signed [AW-1:0] r;
        r = '0;
        if (off == 2'sd1)
        begin
            r = AW'(v);
        end
        else if (off == -2'sd1)
        begin
            r = -AW'(v);
        end
        return r;
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COLS_W-1:0]  cols_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic               mode_reg;

    // Sequencer and grid position.
    state_t             state_reg, state_next;
    logic [CW-1:0]      col_reg;
    logic [ROWS_W-1:0]  row_reg;
    logic [AREA_W-1:0]  total_reg;
    logic [EW-1:0]      win_reg [9];
    logic               interior_reg;
    logic               cmiss_reg;
    logic               emit_cell_reg;
    logic               emit_total_reg;
    logic               grid_end_reg;
    logic [2:0]         t_reg;
    logic [1:0]         part_reg;
    logic [1:0]         sel_reg;
    logic               out_valid_reg;

    // Data path.
    logic [2*EW-1:0]        line_mem [MAX_COLUMNS];
    logic [2*EW-1:0]        rd_data_reg;
    logic [EW-1:0]          sample_reg;
    logic [EW-1:0]          ring_reg [8];
    logic signed [HB-1:0]   zc_reg;
    logic [WHW-1:0]         wh_reg;
    logic [MGW-1:0]         a_mag_reg;
    logic [MGW-1:0]         b_mag_reg;
    logic [1:0]             c_abs_reg;
    logic [SW-1:0]          cx_reg;
    logic [SW-1:0]          cy_reg;
    logic [SW-1:0]          cz_reg;
    logic [2*MULW-1:0]      prod_reg;
    logic [RW-1:0]          rad_reg;
    logic [SUMW-1:0]        sum_reg;
    logic [AREA_W-1:0]      area_value_reg;
    logic                   center_missing_reg;
    logic                   is_total_reg;

    // Combinational signals.
    logic                   accept;
    logic                   out_free;
    logic [EW-1:0]          rd_upper;
    logic [EW-1:0]          rd_middle;
    logic [CMPW-1:0]        col_ext;
    logic [CMPW-1:0]        cols_lim;
    logic [ROWS_W:0]        row_ext;
    logic [ROWS_W:0]        rows_lim;
    logic                   last_col;
    logic                   last_row;
    logic                   interior;
    logic [3:0]             tq;
    logic signed [1:0]      oxp, oyp, oxq, oyq;
    logic signed [DW-1:0]   uz, vz;
    logic signed [AW-1:0]   a_val, b_val;
    logic signed [2:0]      c_val;
    logic [SW-1:0]          sq_x;
    logic [MULW-1:0]        mul_a, mul_b;
    logic [RW-1:0]          rad_add;
    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [RTW-1:0]         sqrt_root;
    logic [RTW-1:0]         area;
    logic [AREA_W:0]        tot_sum;
    logic [AREA_W-1:0]      total_new;

    // Handshake.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            cols_reg   <= COLS_W'(1024);
            rows_reg   <= ROWS_W'(1024);
            mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CELL_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                CFG_CELL_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                CFG_GRID_COLUMNS:  cols_reg   <= cfg_data[COLS_W-1:0];
                CFG_GRID_ROWS:     rows_reg   <= cfg_data[ROWS_W-1:0];
                CFG_PER_CELL_MODE: mode_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Line store: each entry holds the upper and middle rows of one column.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            line_mem[col_reg] <= {rd_middle, sample_reg};
        end
        if (accept)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    assign rd_upper  = rd_data_reg[2*EW-1:EW];
    assign rd_middle = rd_data_reg[EW-1:0];

    // Grid position tests, with the column and row limits clamped.
    always_comb
    begin
        col_ext = CMPW'(col_reg) + CMPW'(1);
        if (cols_reg < COLS_W'(3))
        begin
            cols_lim = CMPW'(3);
        end
        else if (CMPW'(cols_reg) > CMPW'(MAX_COLUMNS))
        begin
            cols_lim = CMPW'(MAX_COLUMNS);
        end
        else
        begin
            cols_lim = CMPW'(cols_reg);
        end
        row_ext  = {1'b0, row_reg} + (ROWS_W + 1)'(1);
        rows_lim = (rows_reg < ROWS_W'(3)) ? (ROWS_W + 1)'(3) : {1'b0, rows_reg};
        last_col = (col_ext >= cols_lim);
        last_row = (row_ext >= rows_lim);
        interior = (col_reg >= CW'(2)) && (row_reg >= ROWS_W'(2));
    end

    // Edge vectors of the current triangle reduced to small coefficients.
    always_comb
    begin
        tq    = {1'b0, t_reg} + 4'd1;
        oxp   = OFF_X[t_reg];
        oyp   = OFF_Y[t_reg];
        oxq   = OFF_X[tq];
        oyq   = OFF_Y[tq];
        uz    = ring_reg[0][HB] ? '0
                : (DW'(signed'(ring_reg[0][HB-1:0])) - DW'(zc_reg));
        vz    = ring_reg[1][HB] ? '0
                : (DW'(signed'(ring_reg[1][HB-1:0])) - DW'(zc_reg));
        a_val = scale(oyp, vz) - scale(oyq, uz);
        b_val = scale(oxq, uz) - scale(oxp, vz);
        c_val = (3'(oxp) * 3'(oyq)) - (3'(oyp) * 3'(oxq));
    end

    // Shared multiplier operands.
    always_comb
    begin
        unique case (sel_reg)
            SQ_CX:   sq_x = cx_reg;
            SQ_CY:   sq_x = cy_reg;
            default: sq_x = cz_reg;
        endcase
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_WH:
            begin
                mul_a = MULW'(width_reg);
                mul_b = MULW'(height_reg);
            end
            ST_MULX:
            begin
                mul_a = MULW'(height_reg);
                mul_b = MULW'(a_mag_reg);
            end
            ST_MULY:
            begin
                mul_a = MULW'(width_reg);
                mul_b = MULW'(b_mag_reg);
            end
            ST_SQM:
            begin
                mul_a = MULW'(sq_x[HALF-1:0]);
                mul_b = (part_reg == PART_LL) ? MULW'(sq_x[HALF-1:0])
                                              : MULW'(sq_x[SW-1:HALF]);
                if (part_reg == PART_HH)
                begin
                    mul_a = MULW'(sq_x[SW-1:HALF]);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Place each partial product of a square at its weight.
    always_comb
    begin
        unique case (part_reg)
            PART_LL: rad_add = RW'(prod_reg);
            PART_LH: rad_add = RW'(prod_reg) << (HALF + 1);
            default: rad_add = RW'(prod_reg) << SW;
        endcase
    end

    // Cell area and saturating running total.
    always_comb
    begin
        area      = sum_reg[SUMW-1:3];
        tot_sum   = {1'b0, total_reg} + (AREA_W + 1)'(area);
        total_new = tot_sum[AREA_W] ? {AREA_W{1'b1}} : tot_sum[AREA_W-1:0];
    end

    // Square root unit.
    assign sqrt_start = (state_reg == ST_ROOT);

    dsaw_sqrt #(
        .RTW (RTW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (interior && !win_reg[5][HB])
                begin
                    state_next = ST_WH;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WH:   state_next = ST_PAIR;
            ST_PAIR: state_next = ST_MULX;
            ST_MULX: state_next = ST_MULY;
            ST_MULY: state_next = ST_LATY;
            ST_LATY: state_next = ST_SQM;
            ST_SQM:  state_next = ST_SQA;
            ST_SQA:
            begin
                if ((sel_reg == SQ_CZ) && (part_reg == PART_HH))
                begin
                    state_next = ST_ROOT;
                end
                else
                begin
                    state_next = ST_SQM;
                end
            end
            ST_ROOT: state_next = ST_ROOTW;
            ST_ROOTW:
            begin
                if (sqrt_done)
                begin
                    state_next = (t_reg == 3'd7) ? ST_DONE : ST_PAIR;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state: window, counters, total, flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            col_reg        <= '0;
            row_reg        <= '0;
            total_reg      <= '0;
            interior_reg   <= 1'b0;
            cmiss_reg      <= 1'b0;
            emit_cell_reg  <= 1'b0;
            emit_total_reg <= 1'b0;
            grid_end_reg   <= 1'b0;
            t_reg          <= '0;
            part_reg       <= PART_LL;
            sel_reg        <= SQ_CX;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Shift the window by one column and take the new column in.
            if (state_reg == ST_LOAD)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2]     <= rd_upper;
                win_reg[5]     <= rd_middle;
                win_reg[8]     <= sample_reg;
                interior_reg   <= interior;
                cmiss_reg      <= interior && win_reg[5][HB];
                emit_cell_reg  <= interior && mode_reg;
                emit_total_reg <= last_col && last_row && !mode_reg;
                grid_end_reg   <= last_col && last_row;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : (row_reg + ROWS_W'(1));
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end

            // Triangle counter.
            if (state_reg == ST_WH)
            begin
                t_reg <= '0;
            end
            else if ((state_reg == ST_ROOTW) && sqrt_done)
            begin
                t_reg <= t_reg + 3'd1;
            end

            // Square and partial-product counters.
            if (state_reg == ST_LATY)
            begin
                part_reg <= PART_LL;
                sel_reg  <= SQ_CX;
            end
            else if (state_reg == ST_SQA)
            begin
                if (part_reg == PART_HH)
                begin
                    part_reg <= PART_LL;
                    sel_reg  <= sel_reg + 2'd1;
                end
                else
                begin
                    part_reg <= part_reg + 2'd1;
                end
            end

            // Finish the item: total and output register.
            if ((state_reg == ST_DONE) && out_free)
            begin
                if (grid_end_reg)
                begin
                    total_reg <= '0;
                end
                else if (interior_reg)
                begin
                    total_reg <= total_new;
                end
                out_valid_reg <= emit_cell_reg || emit_total_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (accept)
        begin
            sample_reg <= {elevation_missing, elevation};
        end

        if (state_reg == ST_LOAD)
        begin
            sum_reg <= '0;
        end

        // Load the neighbour ring and the centre height.
        if (state_reg == ST_WH)
        begin
            for (int i = 0; i < 8; i++)
            begin
                ring_reg[i] <= win_reg[RING_POS[i]];
            end
            zc_reg <= signed'(win_reg[4][HB-1:0]);
        end

        if (state_reg == ST_PAIR)
        begin
            if (t_reg == 3'd0)
            begin
                wh_reg <= prod_reg[WHW-1:0];
            end
            a_mag_reg <= a_val[AW-1] ? MGW'(-a_val) : MGW'(a_val);
            b_mag_reg <= b_val[AW-1] ? MGW'(-b_val) : MGW'(b_val);
            c_abs_reg <= c_val[2] ? 2'(-c_val) : 2'(c_val);
        end

        if (state_reg == ST_MULY)
        begin
            cx_reg <= prod_reg[SW-1:0];
        end

        if (state_reg == ST_LATY)
        begin
            cy_reg  <= prod_reg[SW-1:0];
            rad_reg <= '0;
            if (c_abs_reg == 2'd2)
            begin
                cz_reg <= SW'({wh_reg, 1'b0});
            end
            else if (c_abs_reg == 2'd1)
            begin
                cz_reg <= SW'(wh_reg);
            end
            else
            begin
                cz_reg <= '0;
            end
        end

        if (state_reg == ST_SQA)
        begin
            rad_reg <= rad_reg + rad_add;
        end

        // Add the root and move to the next pair of neighbours.
        if ((state_reg == ST_ROOTW) && sqrt_done)
        begin
            sum_reg <= sum_reg + SUMW'(sqrt_root);
            for (int i = 0; i < 7; i++)
            begin
                ring_reg[i] <= ring_reg[i + 1];
            end
            ring_reg[7] <= ring_reg[0];
        end

        // Output payload.
        if ((state_reg == ST_DONE) && out_free)
        begin
            if (emit_cell_reg)
            begin
                area_value_reg     <= AREA_W'(area);
                center_missing_reg <= cmiss_reg;
                is_total_reg       <= 1'b0;
            end
            else
            begin
                area_value_reg     <= interior_reg ? total_new : total_reg;
                center_missing_reg <= 1'b0;
                is_total_reg       <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign area_value     = area_value_reg;
    assign center_missing = center_missing_reg;
    assign is_total       = is_total_reg;

endmodule

`default_nettype wire

### sim/tb_dem_surface_area_window_unit.sv
// Self-checking testbench for the DEM surface area window unit.
`default_nettype none

module tb_dem_surface_area_window_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dsaw_pkg::*;

    localparam int  MAX_COLS  = 1024;
    localparam int  SETTLE    = 800;
    localparam longint AREA_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

    // One result item as the block presents it.
    typedef struct {
        logic [AREA_W-1:0] area;
        logic              cm;
        logic              tot;
    } area_item_t;

    // One row of the directed stimulus table.
    typedef struct {
        bit                 is_cfg;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic signed [23:0] elev;
        bit                 miss;
        bit                 typed;
        area_item_t         want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [23:0] elevation = '0;
    logic elevation_missing = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [AREA_W-1:0] area_value;
    logic center_missing;
    logic is_total;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dem_surface_area_window_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .elevation(elevation), .elevation_missing(elevation_missing),
        .out_valid(out_valid), .out_stall(out_stall),
        .area_value(area_value), .center_missing(center_missing), .is_total(is_total),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow of the block: registers, line stores, window and counters.
    longint unsigned sh_width = 256, sh_height = 256, sh_cols = 1024, sh_rows = 1024;
    bit sh_per_cell = 1'b0;
    logic [24:0] store_upper [MAX_COLS];
    logic [24:0] store_middle [MAX_COLS];
    logic [24:0] win [3][3];
    longint unsigned col_pos = 0, row_pos = 0, run_total = 0;
    int ring_dx [9] = '{-1, 0, 1, 1, 1, 0, -1, -1, -1};
    int ring_dy [9] = '{-1, -1, -1, 0, 1, 1, 1, 0, -1};

    area_item_t areas_due [$];
    stim_row_t  plan [$];
    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    bit  idling = 1'b1;
    int  stall_left = 0;

    task automatic report(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [127:0] square_of(input longint x);
        logic [63:0] m;
        m = (x < 0) ? 64'(-x) : 64'(x);
        return {64'd0, m} * {64'd0, m};
    endfunction

    // A quarter of the summed eight triangle areas around the window centre, Q16.
    function automatic logic [63:0] window_area();
        longint zc, ux, uy, vx, vy, uz, vz, cx, cy, cz;
        logic [24:0] p, q;
        logic [63:0] acc;
        zc = longint'($signed(win[1][1][23:0]));
        acc = '0;
        for (int t = 0; t < 8; t++) begin
            p = win[1 + ring_dy[t]][1 + ring_dx[t]];
            q = win[1 + ring_dy[t + 1]][1 + ring_dx[t + 1]];
            ux = ring_dx[t] * longint'(sh_width);
            uy = ring_dy[t] * longint'(sh_height);
            vx = ring_dx[t + 1] * longint'(sh_width);
            vy = ring_dy[t + 1] * longint'(sh_height);
            uz = p[24] ? 0 : longint'($signed(p[23:0])) - zc;
            vz = q[24] ? 0 : longint'($signed(q[23:0])) - zc;
            cx = uy * vz - uz * vy;
            cy = uz * vx - ux * vz;
            cz = ux * vy - uy * vx;
            acc += root_floor(square_of(cx) + square_of(cy) + square_of(cz));
        end
        acc = acc >> 3;
        return (acc > AREA_SAT) ? AREA_SAT : acc;
    endfunction

    // Advance the shadow by one accepted item; returns 1 when a result is due.
    function automatic bit predict_area(input logic signed [23:0] e, input bit m,
                                        output area_item_t res);
        longint unsigned cols, rows, idx, a;
        logic [24:0] top, mid, smp;
        bit got;
        got = 1'b0;
        res = '{area: '0, cm: 1'b0, tot: 1'b0};
        cols = (sh_cols < 3) ? 3 : (sh_cols > MAX_COLS) ? MAX_COLS : sh_cols;
        rows = (sh_rows < 3) ? 3 : sh_rows;
        smp = {m, e};
        idx = col_pos % MAX_COLS;
        top = store_upper[idx];
        mid = store_middle[idx];
        store_upper[idx] = mid;
        store_middle[idx] = smp;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = smp;
        if (row_pos >= 2 && col_pos >= 2) begin
            a = win[1][1][24] ? 0 : window_area();
            run_total = (AREA_SAT - run_total < a) ? AREA_SAT : run_total + a;
            if (sh_per_cell) begin
                res = '{area: a[AREA_W-1:0], cm: win[1][1][24], tot: 1'b0};
                got = 1'b1;
            end
        end
        if (col_pos + 1 >= cols) begin
            col_pos = 0;
            if (row_pos + 1 >= rows) begin
                if (!sh_per_cell) begin
                    res = '{area: run_total[AREA_W-1:0], cm: 1'b0, tot: 1'b1};
                    got = 1'b1;
                end
                row_pos = 0;
                run_total = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return got;
    endfunction

    // Wait until every expected result has come back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        wait (areas_due.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write; callers make sure the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input longint unsigned v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_CELL_WIDTH:    sh_width    = v & 24'hFFFFFF;
            CFG_CELL_HEIGHT:   sh_height   = v & 24'hFFFFFF;
            CFG_GRID_COLUMNS:  sh_cols     = v & 11'h7FF;
            CFG_GRID_ROWS:     sh_rows     = v & 16'hFFFF;
            CFG_PER_CELL_MODE: sh_per_cell = v[0];
            default: ;
        endcase
    endtask

    // After an optional random gap, offer one item, hold it until accepted, then queue what it should produce.
    task automatic send_item(input logic signed [23:0] e, input bit m,
                             input bit typed, input area_item_t want);
        area_item_t res;
        if (idling && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        elevation <= e;
        elevation_missing <= m;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (predict_area(e, m, res))
            areas_due.push_back(typed ? want : res);
    endtask

    function automatic logic signed [23:0] pick_height();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return ($urandom_range(0, 1)) ? 24'sh7FFFFF : -24'sh800000;
            default: return 24'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic longint unsigned pick_size();
        case ($urandom_range(0, 4))
            0: return 1;
            1: return 24'hFFFFFF;
            2: return 256;
            default: return $urandom_range(1, 24'hFFFFFF);
        endcase
    endfunction

    // Send whole grids of the current shape so that no stale line store entry is read.
    task automatic send_grids(input int grids, input int miss_pct);
        longint unsigned cols, rows;
        cols = (sh_cols < 3) ? 3 : (sh_cols > MAX_COLS) ? MAX_COLS : sh_cols;
        rows = (sh_rows < 3) ? 3 : sh_rows;
        for (int g = 0; g < grids; g++)
            for (longint unsigned k = 0; k < cols * rows; k++)
                send_item(pick_height(), $urandom_range(0, 99) < miss_pct, 1'b0,
                          '{area: '0, cm: 1'b0, tot: 1'b0});
    endtask

    function automatic void plan_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] v);
        plan.push_back('{is_cfg: 1'b1, index: idx, data: v, elev: '0, miss: 1'b0,
                         typed: 1'b0, want: '{area: '0, cm: 1'b0, tot: 1'b0}});
    endfunction

    function automatic void plan_item(input logic signed [23:0] e, input bit m,
                                      input bit typed, input area_item_t want);
        plan.push_back('{is_cfg: 1'b0, index: '0, data: '0, elev: e, miss: m,
                         typed: typed, want: want});
    endfunction

    // Result side: random stall bursts, and every accepted result checked in order.
    always @(posedge clk) begin
        area_item_t exp_item;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (areas_due.size() == 0) begin
                report($sformatf("unexpected result area=%0d", area_value));
            end else begin
                exp_item = areas_due.pop_front();
                if (area_value !== exp_item.area)
                    report($sformatf("area_value %0d, wanted %0d",
                                     area_value, exp_item.area));
                if (center_missing !== exp_item.cm)
                    report($sformatf("center_missing %b, wanted %b",
                                     center_missing, exp_item.cm));
                if (is_total !== exp_item.tot)
                    report($sformatf("is_total %b, wanted %b", is_total, exp_item.tot));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Stimulus: directed table, wide and tall extremes, then random grids.
    initial begin
        stim_row_t row;
        int phase;
        for (int i = 0; i < MAX_COLS; i++) begin
            store_upper[i] = '0;
            store_middle[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;

        // A flat 3x3 grid at unit spacing gives its centre cell exactly one unit of area.
        plan_cfg(CFG_PER_CELL_MODE, 24'd1);
        plan_cfg(CFG_GRID_COLUMNS, 24'd3);
        plan_cfg(CFG_GRID_ROWS, 24'd3);
        plan_cfg(CFG_CELL_WIDTH, 24'd256);
        plan_cfg(CFG_CELL_HEIGHT, 24'd256);
        for (int i = 0; i < 9; i++)
            plan_item(24'sd0, 1'b0, i == 8, '{area: 63'd65536, cm: 1'b0, tot: 1'b0});
        // A missing centre gives zero area and raises the flag.
        for (int i = 0; i < 9; i++)
            plan_item(24'sd77, i == 4, i == 8, '{area: '0, cm: 1'b1, tot: 1'b0});
        // Total mode with extreme heights and missing neighbours.
        plan_cfg(CFG_PER_CELL_MODE, 24'd0);
        for (int i = 0; i < 9; i++)
            plan_item((i % 2) ? 24'sh7FFFFF : -24'sh800000, i == 1 || i == 6, 1'b0,
                      '{area: '0, cm: 1'b0, tot: 1'b0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg) begin
                drain();
                write_reg(row.index, row.data);
            end else begin
                send_item(row.elev, row.miss, row.typed, row.want);
            end
        end

        // Widest grid (register above the limit clamps to the store size); the second row
        // is cut short by narrowing the columns, and a short third row ends the grid.
        drain();
        write_reg(CFG_GRID_COLUMNS, 2047);
        write_reg(CFG_GRID_ROWS, 3);
        write_reg(CFG_PER_CELL_MODE, 1);
        for (int i = 0; i < MAX_COLS + 6; i++)
            send_item(pick_height(), $urandom_range(0, 9) == 0, 1'b0,
                      '{area: '0, cm: 1'b0, tot: 1'b0});
        drain();
        write_reg(CFG_GRID_COLUMNS, 3);
        for (int i = 0; i < 4; i++)
            send_item(pick_height(), 1'b0, 1'b0, '{area: '0, cm: 1'b0, tot: 1'b0});

        // Tallest row setting, cut short after four rows.
        drain();
        write_reg(CFG_GRID_ROWS, 65535);
        write_reg(CFG_PER_CELL_MODE, 0);
        for (int i = 0; i < 12; i++)
            send_item(pick_height(), 1'b0, 1'b0, '{area: '0, cm: 1'b0, tot: 1'b0});
        drain();
        write_reg(CFG_GRID_ROWS, 3);
        for (int i = 0; i < 3; i++)
            send_item(pick_height(), 1'b0, 1'b0, '{area: '0, cm: 1'b0, tot: 1'b0});

        // Random phases: fresh settings, then whole grids of random heights.
        phase = 0;
        while (items_sent < 1400) begin
            drain();
            write_reg(CFG_CELL_WIDTH, pick_size());
            write_reg(CFG_CELL_HEIGHT, pick_size());
            write_reg(CFG_GRID_COLUMNS, ($urandom_range(0, 5) == 0) ?
                      $urandom_range(0, 2) : $urandom_range(3, 9));
            write_reg(CFG_GRID_ROWS, ($urandom_range(0, 5) == 0) ?
                      $urandom_range(0, 2) : $urandom_range(3, 6));
            write_reg(CFG_PER_CELL_MODE, $urandom_range(0, 1));
            if (items_sent > 1250)
                idling = 1'b0;
            send_grids($urandom_range(1, 3), (phase % 3 == 0) ? 40 : 10);
            phase++;
        end
        in_valid <= 1'b0;

        wait (areas_due.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d elevation items over %0d setting phases; %0d areas checked.",
                 items_sent, phase, results_seen);
        if (error_count == 0)
            $display("tb_dem_surface_area_window_unit: clean");
        else
            $display("tb_dem_surface_area_window_unit: errors");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #40_000_000;
        $display("Timed out with %0d results still due.", areas_due.size());
        $display("tb_dem_surface_area_window_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire
